// ----- rtl/framebuffer_line_rect_fill_top_macros.svh -----
// Assertion helpers used by fbrf_back. Clock aclk, reset aresetn (active low).
`ifndef FRAMEBUFFER_LINE_RECT_FILL_TOP_MACROS_SVH
`define FRAMEBUFFER_LINE_RECT_FILL_TOP_MACROS_SVH

// same-cycle implication
`define FBRF_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FBRF_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/fbrf_pkg.sv -----
package fbrf_pkg;

    localparam int MAX_PIXELS  = 131072;
    localparam int ADDR_W      = $clog2(MAX_PIXELS);
    localparam int LIM_W       = $clog2(MAX_PIXELS + 1);

    localparam int DIM_W       = 11;
    localparam int AREA_W      = 2 * DIM_W;
    localparam int COLOR_W     = 8;
    localparam int COORD_W     = 12;
    localparam int PT_W        = COORD_W + 1;
    localparam int LIN_W       = PT_W + DIM_W + 2;

    localparam int ACT_W       = 3;
    localparam int S_DATA_W    = 56;
    localparam int S_USER_W    = 4;
    localparam int M_DATA_W    = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [ACT_W-1:0] ACT_POINT   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_HLINE   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_VLINE   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FILL    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_OUTLINE = 3'd4;
    localparam logic [ACT_W-1:0] ACT_READ    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_COLOR = 2'd2;

    localparam logic [1:0] OP_NONE    = 2'd0;
    localparam logic [1:0] OP_SPAN    = 2'd1;
    localparam logic [1:0] OP_OUTLINE = 2'd2;
    localparam logic [1:0] OP_READ    = 2'd3;

    localparam logic [DIM_W-1:0]   RESET_WIDTH  = 11'd320;
    localparam logic [DIM_W-1:0]   RESET_HEIGHT = 11'd240;
    localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'd0;
    localparam int RESET_AREA  = 320 * 240;
    localparam int RESET_LIMIT = (RESET_AREA < MAX_PIXELS) ? RESET_AREA : MAX_PIXELS;

    // one queued command: a row range y0..y1 over columns x0..x1, or the
    // corners of an outline, or the point of a read
    typedef struct packed {
        logic [1:0]                op;
        logic [COLOR_W-1:0]        color;
        logic signed [PT_W-1:0]    x0;
        logic signed [PT_W-1:0]    x1;
        logic signed [PT_W-1:0]    y0;
        logic signed [PT_W-1:0]    y1;
    } fbrf_cmd_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [LIM_W-1:0] limit;
    } fbrf_geom_t;

endpackage

// ----- rtl/framebuffer_line_rect_fill_top.sv -----
// Byte-per-pixel drawing engine: point, horizontal/vertical line, filled
// rectangle, rectangle outline and pixel read-back over an on-chip buffer.
// Input commands arrive on s_t*; each yields exactly one result item on m_t*
// (read_data/in_range for reads, 0/1 for drawing, 0/0 for unknown actions).
// cfg_we/cfg_addr/cfg_wdata write frame width, height and initial color;
// write only while no command is in flight.
// The front end decodes a command in its accept cycle into a 4-deep queue,
// so commands are taken while the back end is still drawing.
// Back end steps per command: a start state, a pass state per pass, per row
// the multiply, add, clip and first write states, the write state repeating
// per further pixel, and a done state that hands over the result. An outline runs four passes.
// A read goes through the multiply, add, range check and, when in range, memory-wait states.
// Pixel writes are one per cycle within a row span, through the buffer's single write port.
// Reset clears the queue, the result register and the control state and
// loads width 320, height 240, color 0; pixel memory is not cleared.
// If m_tready is low the result waits in the output register, the back end
// stops at its next result and the queue fills, after which s_tready drops.
module framebuffer_line_rect_fill_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [fbrf_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [fbrf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pos_x[11:0], pos_y[23:12], reach_x[35:24], reach_y[47:36], draw_color[55:48]
    input  logic [fbrf_pkg::S_DATA_W-1:0]    s_tdata,
    // action[2:0], keep_color[3]
    input  logic [fbrf_pkg::S_USER_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // read_data[7:0]
    output logic [fbrf_pkg::M_DATA_W-1:0]    m_tdata,
    // in_range[0]
    output logic                             m_tuser
);

    fbrf_pkg::fbrf_cmd_t  push_cmd, head_cmd;
    fbrf_pkg::fbrf_geom_t geom;
    logic                 push, full, pop, head_valid;

    fbrf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_push    (push),
        .q_cmd     (push_cmd),
        .q_full    (full),
        .geom      (geom)
    );

    fbrf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    fbrf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .geom       (geom),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

// ----- rtl/fbrf_ram.sv -----
module fbrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/fbrf_front.sv -----
module fbrf_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [fbrf_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [fbrf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fbrf_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic [fbrf_pkg::S_USER_W-1:0]     s_tuser,
    output logic                              q_push,
    output fbrf_pkg::fbrf_cmd_t               q_cmd,
    input  logic                              q_full,
    output fbrf_pkg::fbrf_geom_t              geom
);

    logic [fbrf_pkg::DIM_W-1:0]   width_reg,      width_next;
    logic [fbrf_pkg::DIM_W-1:0]   height_reg,     height_next;
    logic [fbrf_pkg::COLOR_W-1:0] cur_color_reg,  cur_color_next;
    logic [fbrf_pkg::LIM_W-1:0]   limit_reg,      limit_next;
    logic [fbrf_pkg::AREA_W-1:0]  area;

    logic [fbrf_pkg::ACT_W-1:0]          action;
    logic                                keep;
    logic signed [fbrf_pkg::COORD_W-1:0] px, py, rx, ry;
    logic [fbrf_pkg::COLOR_W-1:0]        dcol;
    logic signed [fbrf_pkg::PT_W-1:0]    px_e, py_e, rx_e, ry_e, x_sum, y_sum;
    logic                                accept;

    assign action = s_tuser[2:0];
    assign keep   = s_tuser[3];
    assign px     = s_tdata[11:0];
    assign py     = s_tdata[23:12];
    assign rx     = s_tdata[35:24];
    assign ry     = s_tdata[47:36];
    assign dcol   = s_tdata[55:48];

    assign px_e  = fbrf_pkg::PT_W'(px);
    assign py_e  = fbrf_pkg::PT_W'(py);
    assign rx_e  = fbrf_pkg::PT_W'(rx);
    assign ry_e  = fbrf_pkg::PT_W'(ry);
    assign x_sum = px_e + rx_e;
    assign y_sum = py_e + ry_e;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign q_push   = accept;

    always_comb begin
        q_cmd.op    = fbrf_pkg::OP_NONE;
        q_cmd.color = keep ? cur_color_reg : dcol;
        q_cmd.x0    = px_e;
        q_cmd.x1    = px_e;
        q_cmd.y0    = py_e;
        q_cmd.y1    = py_e;
        case (action)
            fbrf_pkg::ACT_POINT: begin
                q_cmd.op = fbrf_pkg::OP_SPAN;
            end
            fbrf_pkg::ACT_HLINE: begin
                q_cmd.op = fbrf_pkg::OP_SPAN;
                q_cmd.x1 = rx_e;
            end
            fbrf_pkg::ACT_VLINE: begin
                q_cmd.op = fbrf_pkg::OP_SPAN;
                q_cmd.y1 = ry_e;
            end
            fbrf_pkg::ACT_FILL: begin
                q_cmd.op = fbrf_pkg::OP_SPAN;
                q_cmd.x1 = x_sum;
                q_cmd.y1 = y_sum;
            end
            fbrf_pkg::ACT_OUTLINE: begin
                q_cmd.op = fbrf_pkg::OP_OUTLINE;
                q_cmd.x1 = x_sum;
                q_cmd.y1 = y_sum;
            end
            fbrf_pkg::ACT_READ: begin
                q_cmd.op = fbrf_pkg::OP_READ;
            end
            default: begin
                q_cmd.op = fbrf_pkg::OP_NONE;
            end
        endcase
    end

    assign area = width_reg * height_reg;

    always_comb begin
        width_next     = width_reg;
        height_next    = height_reg;
        cur_color_next = cur_color_reg;
        limit_next     = (area > fbrf_pkg::AREA_W'(fbrf_pkg::MAX_PIXELS)) ?
                         fbrf_pkg::LIM_W'(fbrf_pkg::MAX_PIXELS) :
                         fbrf_pkg::LIM_W'(area);
        if (cfg_we) begin
            case (cfg_addr)
                fbrf_pkg::CFG_WIDTH:      width_next     = cfg_wdata;
                fbrf_pkg::CFG_HEIGHT:     height_next    = cfg_wdata;
                fbrf_pkg::CFG_INIT_COLOR: cur_color_next = cfg_wdata[fbrf_pkg::COLOR_W-1:0];
                default: ;
            endcase
        end else if (accept && action <= fbrf_pkg::ACT_OUTLINE && !keep) begin
            cur_color_next = dcol;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= fbrf_pkg::RESET_WIDTH;
            height_reg    <= fbrf_pkg::RESET_HEIGHT;
            cur_color_reg <= fbrf_pkg::RESET_COLOR;
            limit_reg     <= fbrf_pkg::LIM_W'(fbrf_pkg::RESET_LIMIT);
        end else begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            cur_color_reg <= cur_color_next;
            limit_reg     <= limit_next;
        end
    end

    assign geom.width = width_reg;
    assign geom.limit = limit_reg;

endmodule

// ----- rtl/fbrf_queue.sv -----
module fbrf_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  fbrf_pkg::fbrf_cmd_t  push_cmd,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output fbrf_pkg::fbrf_cmd_t  head_cmd
);

    fbrf_pkg::fbrf_cmd_t          slot_reg [fbrf_pkg::QUEUE_DEPTH];
    logic [fbrf_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [fbrf_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [fbrf_pkg::QPTR_W:0]    count_reg,  count_next;
    logic                         do_push, do_pop;

    assign full       = count_reg == (fbrf_pkg::QPTR_W+1)'(fbrf_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/fbrf_back.sv -----
`include "framebuffer_line_rect_fill_top_macros.svh"

module fbrf_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  fbrf_pkg::fbrf_geom_t             geom,
    input  logic                             head_valid,
    input  fbrf_pkg::fbrf_cmd_t              head_cmd,
    output logic                             pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fbrf_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                             m_tuser
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_PASS    = 4'd1;
    localparam logic [3:0] ST_MUL     = 4'd2;
    localparam logic [3:0] ST_ADD     = 4'd3;
    localparam logic [3:0] ST_CLIP    = 4'd4;
    localparam logic [3:0] ST_WRITE   = 4'd5;
    localparam logic [3:0] ST_RD_CHK  = 4'd6;
    localparam logic [3:0] ST_RD_WAIT = 4'd7;
    localparam logic [3:0] ST_DONE    = 4'd8;

    localparam logic [1:0] PASS_LAST  = 2'd3;

    localparam int PT_W  = fbrf_pkg::PT_W;
    localparam int LIN_W = fbrf_pkg::LIN_W;
    localparam int AW    = fbrf_pkg::ADDR_W;

    logic [3:0]                    state_reg,    state_next;
    fbrf_pkg::fbrf_cmd_t           cmd_reg,      cmd_next;
    logic [1:0]                    pass_reg,     pass_next;
    logic signed [PT_W-1:0]        row_reg,      row_next;
    logic signed [PT_W-1:0]        row_end_reg,  row_end_next;
    logic signed [PT_W-1:0]        col0_reg,     col0_next;
    logic signed [PT_W-1:0]        col1_reg,     col1_next;
    logic signed [LIN_W-1:0]       prod_reg,     prod_next;
    logic signed [LIN_W-1:0]       lo_reg,       lo_next;
    logic signed [LIN_W-1:0]       hi_reg,       hi_next;
    logic [AW-1:0]                 addr_reg,     addr_next;
    logic [AW-1:0]                 end_reg,      end_next;
    logic [fbrf_pkg::COLOR_W-1:0]  res_data_reg, res_data_next;
    logic                          res_range_reg, res_range_next;
    logic                          m_valid_reg,  m_valid_next;
    logic [fbrf_pkg::M_DATA_W-1:0] m_data_reg,   m_data_next;
    logic                          m_user_reg,   m_user_next;

    logic signed [PT_W-1:0]          pr0, pr1, pc0, pc1;
    logic                            pass_empty, pass_last, row_last;
    logic signed [fbrf_pkg::DIM_W:0] width_s;
    logic signed [PT_W+fbrf_pkg::DIM_W:0] mul_w;
    logic signed [LIN_W-1:0]         lim_s, lim_m1, lo_c, hi_c;
    logic                            ram_we;
    logic [fbrf_pkg::COLOR_W-1:0]    ram_rdata;

    fbrf_ram #(
        .WIDTH (fbrf_pkg::COLOR_W),
        .DEPTH (fbrf_pkg::MAX_PIXELS)
    ) u_pixels (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (cmd_reg.color),
        .raddr (lo_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // row and column bounds of the current pass
    always_comb begin
        pr0 = cmd_reg.y0;
        pr1 = cmd_reg.y1;
        pc0 = cmd_reg.x0;
        pc1 = cmd_reg.x1;
        if (cmd_reg.op == fbrf_pkg::OP_OUTLINE) begin
            case (pass_reg)
                2'd0:    pc1 = cmd_reg.x0;
                2'd1:    pc0 = cmd_reg.x1;
                2'd2:    pr1 = cmd_reg.y0;
                default: pr0 = cmd_reg.y1;
            endcase
        end
    end

    assign pass_empty = (pr1 < pr0) || (pc1 < pc0);
    assign pass_last  = (cmd_reg.op != fbrf_pkg::OP_OUTLINE) || (pass_reg == PASS_LAST);
    assign row_last   = row_reg == row_end_reg;

    assign width_s = signed'({1'b0, geom.width});
    assign mul_w   = row_reg * width_s;

    assign lim_s  = LIN_W'(signed'({1'b0, geom.limit}));
    assign lim_m1 = lim_s - signed'(LIN_W'(1));
    assign lo_c   = lo_reg[LIN_W-1] ? '0 : lo_reg;
    assign hi_c   = (hi_reg > lim_m1) ? lim_m1 : hi_reg;

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        pass_next      = pass_reg;
        row_next       = row_reg;
        row_end_next   = row_end_reg;
        col0_next      = col0_reg;
        col1_next      = col1_reg;
        prod_next      = prod_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        addr_next      = addr_reg;
        end_next       = end_reg;
        res_data_next  = res_data_reg;
        res_range_next = res_range_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;

        case (state_reg)
            ST_IDLE: begin
                if (head_valid) begin
                    pop            = 1'b1;
                    cmd_next       = head_cmd;
                    pass_next      = '0;
                    row_next       = head_cmd.y0;
                    col0_next      = head_cmd.x0;
                    res_data_next  = '0;
                    res_range_next = 1'b1;
                    case (head_cmd.op)
                        fbrf_pkg::OP_SPAN,
                        fbrf_pkg::OP_OUTLINE: state_next = ST_PASS;
                        fbrf_pkg::OP_READ:    state_next = ST_MUL;
                        default: begin
                            res_range_next = 1'b0;
                            state_next     = ST_DONE;
                        end
                    endcase
                end
            end
            ST_PASS: begin
                if (pass_empty) begin
                    if (pass_last) begin
                        state_next = ST_DONE;
                    end else begin
                        pass_next  = pass_reg + 1'b1;
                        state_next = ST_PASS;
                    end
                end else begin
                    row_next     = pr0;
                    row_end_next = pr1;
                    col0_next    = pc0;
                    col1_next    = pc1;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = LIN_W'(mul_w);
                state_next = ST_ADD;
            end
            ST_ADD: begin
                lo_next    = prod_reg + LIN_W'(col0_reg);
                hi_next    = prod_reg + LIN_W'(col1_reg);
                state_next = (cmd_reg.op == fbrf_pkg::OP_READ) ? ST_RD_CHK : ST_CLIP;
            end
            ST_CLIP: begin
                if (lo_c <= hi_c) begin
                    addr_next  = lo_c[AW-1:0];
                    end_next   = hi_c[AW-1:0];
                    state_next = ST_WRITE;
                end else if (!row_last) begin
                    row_next   = row_reg + 1'b1;
                    state_next = ST_MUL;
                end else if (pass_last) begin
                    state_next = ST_DONE;
                end else begin
                    pass_next  = pass_reg + 1'b1;
                    state_next = ST_PASS;
                end
            end
            ST_WRITE: begin
                ram_we = 1'b1;
                if (addr_reg != end_reg) begin
                    addr_next = addr_reg + 1'b1;
                end else if (!row_last) begin
                    row_next   = row_reg + 1'b1;
                    state_next = ST_MUL;
                end else if (pass_last) begin
                    state_next = ST_DONE;
                end else begin
                    pass_next  = pass_reg + 1'b1;
                    state_next = ST_PASS;
                end
            end
            ST_RD_CHK: begin
                if (!lo_reg[LIN_W-1] && lo_reg < lim_s) begin
                    state_next = ST_RD_WAIT;
                end else begin
                    res_range_next = 1'b0;
                    state_next     = ST_DONE;
                end
            end
            ST_RD_WAIT: begin
                res_data_next = ram_rdata;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_data_reg;
                    m_user_next  = res_range_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pass_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pass_reg    <= pass_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        row_reg       <= row_next;
        row_end_reg   <= row_end_next;
        col0_reg      <= col0_next;
        col1_reg      <= col1_next;
        prod_reg      <= prod_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        addr_reg      <= addr_next;
        end_reg       <= end_next;
        res_data_reg  <= res_data_next;
        res_range_reg <= res_range_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `FBRF_IMPLIES(a_write_in_buffer, ram_we, fbrf_pkg::LIM_W'(addr_reg) < geom.limit, "pixel write beyond buffer bound")
    `FBRF_IMPLIES(a_span_order, state_reg == ST_WRITE, addr_reg <= end_reg, "span cursor passed its end")
    `FBRF_NEXT(a_pop_starts_work, pop, state_reg != ST_IDLE, "command popped but back end stayed idle")

endmodule

// ----- tb/sv/framebuffer_line_rect_fill_top_tb.sv -----
module framebuffer_line_rect_fill_top_tb;
    import fbrf_pkg::*;

    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int PHASE_ITEMS = 135;
    localparam int COORD_MIN   = -2048;
    localparam int COORD_MAX   = 2047;

    typedef struct packed {
        logic [ACT_W-1:0]          action;
        logic                      keep;
        logic [COLOR_W-1:0]        color;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] rx;
        logic signed [COORD_W-1:0] ry;
    } draw_cmd_t;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel;
        logic               in_buf;
    } pixel_reply_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = CFG_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [S_USER_W-1:0]   s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;

    // frame model
    logic [COLOR_W-1:0] fb_mem [0:MAX_PIXELS-1];
    int                 fb_width  = 320;
    int                 fb_height = 240;
    logic [COLOR_W-1:0] pen_color = 8'd0;

    // pixels known to hold a value, so reads never touch unwritten memory
    bit px_seen [0:MAX_PIXELS-1];
    int seen_addr [$];

    draw_cmd_t    cmd_backlog [$];
    pixel_reply_t answer_q [$];
    draw_cmd_t    drv_cmd;
    pixel_reply_t want_reply;

    int burst_left  = 1;
    int gap_left    = 0;
    int ready_pct   = 100;
    int ready_left  = 0;
    int cyc_cnt     = 0;
    int err_cnt     = 0;
    int checked_cnt = 0;
    int draw_cnt    = 0;
    int read_cnt    = 0;
    int read_hit    = 0;
    int spare_cnt   = 0;
    int frame_cnt   = 0;

    framebuffer_line_rect_fill_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic longint fb_limit();
        longint area;
        area = longint'(fb_width) * longint'(fb_height);
        return (area < MAX_PIXELS) ? area : longint'(MAX_PIXELS);
    endfunction

    function automatic void paint_span(longint a, longint b);
        longint lim;
        longint i;
        lim = fb_limit();
        if (a < 0) a = 0;
        if (b > lim - 1) b = lim - 1;
        for (i = a; i <= b; i++) fb_mem[i] = pen_color;
    endfunction

    function automatic void paint_row(longint y, longint x0, longint x1);
        longint base;
        base = y * fb_width;
        if (x1 >= x0) paint_span(base + x0, base + x1);
    endfunction

    function automatic void paint_column(longint x, longint y0, longint y1);
        longint y;
        for (y = y0; y <= y1; y++) paint_span(y * fb_width + x, y * fb_width + x);
    endfunction

    function automatic pixel_reply_t render_cmd(draw_cmd_t c);
        pixel_reply_t r;
        longint x, y, w, h, lin, i;
        x = $signed(c.px);
        y = $signed(c.py);
        w = $signed(c.rx);
        h = $signed(c.ry);
        r.pixel = '0;
        r.in_buf = 1'b1;
        if (c.action <= ACT_OUTLINE && !c.keep) pen_color = c.color;
        if (c.action <= ACT_OUTLINE) draw_cnt++;
        case (c.action)
            ACT_POINT: paint_row(y, x, x);
            ACT_HLINE: paint_row(y, x, w);
            ACT_VLINE: paint_column(x, y, h);
            ACT_FILL: begin
                for (i = 0; i <= h; i++) paint_row(y + i, x, x + w);
            end
            ACT_OUTLINE: begin
                paint_column(x, y, y + h);
                paint_column(x + w, y, y + h);
                paint_row(y, x, x + w);
                paint_row(y + h, x, x + w);
            end
            ACT_READ: begin
                read_cnt++;
                lin = y * fb_width + x;
                if (lin >= 0 && lin < fb_limit()) begin
                    r.pixel = fb_mem[lin];
                    read_hit++;
                end else begin
                    r.in_buf = 1'b0;
                end
            end
            default: begin
                r.in_buf = 1'b0;
                spare_cnt++;
            end
        endcase
        return r;
    endfunction

    function automatic int rand_in(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int clip_coord(longint v);
        if (v < COORD_MIN) return COORD_MIN;
        if (v > COORD_MAX) return COORD_MAX;
        return int'(v);
    endfunction

    function automatic int near_x();
        return rand_in(-4, fb_width + 4);
    endfunction

    function automatic int near_y();
        int rows;
        rows = (fb_width == 0) ? 0 : int'(fb_limit() / fb_width);
        return rand_in(-4, (rows > COORD_MAX - 4) ? COORD_MAX : rows + 4);
    endfunction

    function automatic void note_pixel(longint x, longint y);
        longint lin;
        lin = y * fb_width + x;
        if (lin >= 0 && lin < fb_limit() && !px_seen[lin]) begin
            px_seen[lin] = 1'b1;
            seen_addr.push_back(int'(lin));
        end
    endfunction

    function automatic void post(draw_cmd_t c);
        longint x, y, w, h;
        x = $signed(c.px);
        y = $signed(c.py);
        w = $signed(c.rx);
        h = $signed(c.ry);
        case (c.action)
            ACT_POINT: note_pixel(x, y);
            ACT_HLINE: begin
                if (w >= x) begin
                    note_pixel(x, y);
                    note_pixel(w, y);
                end
            end
            ACT_VLINE: begin
                if (h >= y) begin
                    note_pixel(x, y);
                    note_pixel(x, h);
                end
            end
            ACT_FILL, ACT_OUTLINE: begin
                if (w >= 0 && h >= 0) begin
                    note_pixel(x, y);
                    note_pixel(x + w, y + h);
                end
            end
            default: ;
        endcase
        cmd_backlog.push_back(c);
    endfunction

    function automatic draw_cmd_t mk_cmd(logic [ACT_W-1:0] act, int x, int y, int rx, int ry,
                                         logic [COLOR_W-1:0] color, logic keep);
        draw_cmd_t c;
        c.action = act;
        c.keep = keep;
        c.color = color;
        c.px = COORD_W'(x);
        c.py = COORD_W'(y);
        c.rx = COORD_W'(rx);
        c.ry = COORD_W'(ry);
        return c;
    endfunction

    function automatic draw_cmd_t random_cmd();
        draw_cmd_t c;
        int sel, shape, x, y, w, h;
        bit wild, placed;
        longint lin, a, yy, xx;
        sel = $urandom_range(0, 99);
        wild = ($urandom_range(0, 4) == 0);
        x = wild ? rand_in(COORD_MIN, COORD_MAX) : near_x();
        y = wild ? rand_in(COORD_MIN, COORD_MAX) : near_y();
        c.rx = COORD_W'($urandom);
        c.ry = COORD_W'($urandom);
        c.color = COLOR_W'($urandom);
        c.keep = ($urandom_range(0, 3) == 0);
        c.action = ACT_POINT;
        if (sel < 14) begin
            c.action = ACT_POINT;
        end else if (sel < 28) begin
            c.action = ACT_HLINE;
            if (!wild) begin
                c.rx = COORD_W'(clip_coord(x + (($urandom_range(0, 7) == 0) ?
                                                rand_in(-3, 1100) : rand_in(-3, 40))));
            end
        end else if (sel < 40) begin
            c.action = ACT_VLINE;
            if (!wild) begin
                c.ry = COORD_W'(clip_coord(y + (($urandom_range(0, 7) == 0) ?
                                                rand_in(-3, 400) : rand_in(-3, 30))));
            end
        end else if (sel < 68) begin
            c.action = (sel < 55) ? ACT_FILL : ACT_OUTLINE;
            shape = $urandom_range(0, 15);
            if (shape == 0) begin
                w = rand_in(0, COORD_MAX);
                h = rand_in(0, 2);
            end else if (shape == 1) begin
                w = rand_in(0, 2);
                h = rand_in(0, COORD_MAX);
            end else if (shape == 2) begin
                w = rand_in(COORD_MIN, -1);
                h = rand_in(COORD_MIN, COORD_MAX);
            end else if (shape == 3) begin
                w = rand_in(0, COORD_MAX);
                h = rand_in(COORD_MIN, -1);
            end else begin
                w = rand_in(-2, 20);
                h = rand_in(-2, 14);
            end
            c.rx = COORD_W'(w);
            c.ry = COORD_W'(h);
        end else if (sel < 95) begin
            c.action = ACT_READ;
            placed = 1'b0;
            if (wild || $urandom_range(0, 3) == 0) begin
                lin = longint'(y) * fb_width + x;
                placed = (lin < 0 || lin >= fb_limit() || px_seen[lin]);
            end
            if (!placed && seen_addr.size() != 0 && fb_width != 0) begin
                a = seen_addr[$urandom_range(0, seen_addr.size() - 1)];
                yy = a / fb_width + rand_in(-1, 1);
                xx = a - yy * fb_width;
                if (yy >= COORD_MIN && yy <= COORD_MAX && xx >= COORD_MIN && xx <= COORD_MAX) begin
                    x = int'(xx);
                    y = int'(yy);
                    placed = 1'b1;
                end
            end
            if (!placed) begin
                // lands outside the buffer: below address zero, or at zero when width is 0
                x = 0;
                y = -1;
            end
        end else begin
            c.action = $urandom_range(0, 1) ? ACT_SPARE_LO : ACT_SPARE_HI;
        end
        c.px = COORD_W'(x);
        c.py = COORD_W'(y);
        return c;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_WIDTH:      fb_width = val;
            CFG_HEIGHT:     fb_height = val;
            CFG_INIT_COLOR: pen_color = COLOR_W'(val);
            default: ;
        endcase
    endtask

    task automatic set_frame(int w, int h, int color);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_INIT_COLOR, color);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        while (cmd_backlog.size() != 0 || s_tvalid || answer_q.size() != 0) @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_phase(int n);
        frame_cnt++;
        @(negedge aclk);
        repeat (n) post(random_cmd());
        wait_idle();
    endtask

    // sender: bursts with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                answer_q.push_back(render_cmd(drv_cmd));
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || cmd_backlog.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    s_tvalid <= 1'b0;
                end else begin
                    drv_cmd = cmd_backlog.pop_front();
                    s_tdata <= {drv_cmd.color, drv_cmd.ry, drv_cmd.rx, drv_cmd.py, drv_cmd.px};
                    s_tuser <= {drv_cmd.keep, drv_cmd.action};
                    s_tvalid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // receiver: stretches of full, half and sparse readiness
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (ready_left == 0) begin
                case ($urandom_range(0, 2))
                    0:       ready_pct = 100;
                    1:       ready_pct = 50;
                    default: ready_pct = 10;
                endcase
                ready_left = $urandom_range(16, 160);
            end else begin
                ready_left--;
            end
            m_tready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            checked_cnt++;
            if (answer_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected item, read_data %02h in_range %0b",
                         $time, m_tdata, m_tuser);
            end else begin
                want_reply = answer_q.pop_front();
                if (m_tdata !== want_reply.pixel) begin
                    err_cnt++;
                    $display("%0t: read_data expected %02h, got %02h",
                             $time, want_reply.pixel, m_tdata);
                end
                if (m_tuser !== want_reply.in_buf) begin
                    err_cnt++;
                    $display("%0t: in_range expected %0b, got %0b",
                             $time, want_reply.in_buf, m_tuser);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cyc_cnt++;
        if (cyc_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cyc_cnt, answer_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        frame_cnt++;
        @(negedge aclk);
        post(mk_cmd(ACT_POINT, 0, 0, 0, 0, 8'h00, 1'b0));
        post(mk_cmd(ACT_POINT, 319, 239, 0, 0, 8'hFF, 1'b0));
        post(mk_cmd(ACT_POINT, 320, 239, 0, 0, 8'h11, 1'b0));
        post(mk_cmd(ACT_POINT, -1, 0, 0, 0, 8'h22, 1'b0));
        post(mk_cmd(ACT_POINT, 320, 0, 0, 0, 8'hA5, 1'b0));
        post(mk_cmd(ACT_HLINE, COORD_MIN, 5, COORD_MAX, 0, 8'h5A, 1'b0));
        post(mk_cmd(ACT_HLINE, 10, 6, 9, 0, 8'h66, 1'b0));
        post(mk_cmd(ACT_VLINE, 7, COORD_MIN, 0, COORD_MAX, 8'h3C, 1'b0));
        post(mk_cmd(ACT_VLINE, 8, 4, 0, 3, 8'h77, 1'b0));
        post(mk_cmd(ACT_FILL, 2, 3, COORD_MAX, 0, 8'h00, 1'b1));
        post(mk_cmd(ACT_FILL, 2, 3, 0, COORD_MAX, 8'h81, 1'b0));
        post(mk_cmd(ACT_FILL, 20, 20, -1, 4, 8'h90, 1'b0));
        post(mk_cmd(ACT_FILL, 20, 20, 4, COORD_MIN, 8'h91, 1'b0));
        post(mk_cmd(ACT_OUTLINE, 100, 100, 5, 3, 8'hC3, 1'b0));
        post(mk_cmd(ACT_OUTLINE, 110, 110, -1, 3, 8'hC4, 1'b0));
        post(mk_cmd(ACT_OUTLINE, 120, 120, 3, -1, 8'hC5, 1'b0));
        post(mk_cmd(ACT_OUTLINE, 130, 130, 0, 0, 8'hC6, 1'b0));
        post(mk_cmd(ACT_READ, 0, 0, 0, 0, 8'hFF, 1'b0));
        post(mk_cmd(ACT_READ, 319, 239, COORD_MAX, COORD_MAX, 8'h00, 1'b1));
        post(mk_cmd(ACT_READ, 0, 1, 0, 0, 8'h12, 1'b0));
        post(mk_cmd(ACT_READ, COORD_MIN, COORD_MIN, 0, 0, 8'h34, 1'b0));
        post(mk_cmd(ACT_READ, COORD_MAX, COORD_MAX, 0, 0, 8'h56, 1'b0));
        // color survives the reads
        post(mk_cmd(ACT_POINT, 50, 50, 0, 0, 8'h00, 1'b1));
        post(mk_cmd(ACT_READ, 50, 50, 0, 0, 8'h00, 1'b0));
        post(mk_cmd(ACT_SPARE_LO, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 8'hFF, 1'b1));
        post(mk_cmd(ACT_SPARE_HI, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 8'h00, 1'b0));
        wait_idle();

        run_phase(PHASE_ITEMS);
        set_frame(1024, 1024, 255);
        run_phase(PHASE_ITEMS);
        set_frame(1, 1, 0);
        run_phase(PHASE_ITEMS);
        set_frame(37, 19, $urandom_range(0, 255));
        run_phase(PHASE_ITEMS);
        set_frame(50, 0, $urandom_range(0, 255));
        run_phase(12);
        set_frame(0, 50, $urandom_range(0, 255));
        run_phase(12);
        set_frame(1024, 128, $urandom_range(0, 255));
        run_phase(PHASE_ITEMS);
        set_frame(1, 1024, $urandom_range(0, 255));
        run_phase(PHASE_ITEMS);
        set_frame(640, 480, $urandom_range(0, 255));
        run_phase(PHASE_ITEMS);
        set_frame(320, 240, 0);
        run_phase(PHASE_ITEMS);

        repeat (20) @(posedge aclk);
        $display("%0d frame geometries: %0d draw commands, %0d reads (%0d inside buffer), %0d %s",
                 frame_cnt, draw_cnt, read_cnt, read_hit, spare_cnt, "spare opcodes");
        $display("%0d results checked, %0d mismatches", checked_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
